/* sv/mpmp_pkg.sv */
// types and constants shared by the min-plus matrix product block
package mpmp_pkg;

  localparam int MAX_DIM  = 16;
  localparam int WEIGHT_W = 32;
  localparam int CFG_W    = $clog2(MAX_DIM + 1);
  localparam int IDX_W    = $clog2(MAX_DIM);
  localparam int VALUE_W  = WEIGHT_W;
  localparam int TYPE_W   = 2;
  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(MAX_DIM);

  typedef enum logic [TYPE_W-1:0] {
    REQ_WR_A    = 2'd0,
    REQ_WR_B    = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [VALUE_W-1:0] weight;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   out_row;
    logic [IDX_W-1:0]   out_col;
    logic [VALUE_W-1:0] out_value;
    logic               last;
  } out_res_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } acc_ctl_t;

endpackage

/* sv/min_plus_matrix_product.sv */
// top level of the min-plus matrix product block
// Usage:
//   in_*  : requests; write A[row][col], write B[row][col], or compute product row.
//   out_* : one result per column 0 .. D-1 of the computed row, last on column D-1.
//   cfg_* : writes active_dim (D), always ready; write it only while idle.
// A write request is stored when accepted. A compute request reads A[row][k] and
// B[k][c] from the two stores, one pair per cycle through one adder and one
// comparator; each column goes through the D reads, the read register, the
// adder and min registers and the output load, and the columns of a row are
// worked one after another.
// Only one request is worked on at a time; in_ready is high while idle, and a
// new request is taken while the final result still waits in the output
// register. When the receiver stalls, the result holds in the output register
// and the next column waits before loading it.
// Reset clears the control state and sets D to 16; store contents are
// undefined until written. Rows and columns at or beyond MAX_DIM are ignored
// on writes; a compute of a row at or beyond D gives no result.
module min_plus_matrix_product (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  mpmp_pkg::in_req_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mpmp_pkg::out_res_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mpmp_pkg::CFG_W-1:0]   cfg_data
);

  localparam int MAX_DIM  = mpmp_pkg::MAX_DIM;
  localparam int WEIGHT_W = mpmp_pkg::WEIGHT_W;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);

  logic [mpmp_pkg::CFG_W-1:0] active_dim_r;
  logic [DW-1:0]              dim;
  mpmp_pkg::state_t           state_r, state_nxt;
  logic [CW-1:0]              row_r, k_r, c_r;
  logic                       k_last, c_last;
  logic                       accept, is_compute, row_ok, wr_ok;
  logic                       we_a, we_b;
  logic [AW-1:0]              waddr, raddr_a, raddr_b;
  logic [WEIGHT_W-1:0]        wdata, rdata_a, rdata_b, best;
  logic                       done;
  mpmp_pkg::acc_ctl_t         issue, issue_d_r;
  logic                       out_free, emit;
  logic                       out_valid_r;
  mpmp_pkg::out_res_t         out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_dim_r <= mpmp_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_dim_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    if (active_dim_r == '0) begin
      dim = DW'(1);
    end else if (int'(active_dim_r) > MAX_DIM) begin
      dim = DW'(MAX_DIM);
    end else begin
      dim = DW'(active_dim_r);
    end
  end

  assign accept     = in_valid && in_ready;
  assign is_compute = in_data.req_type == mpmp_pkg::REQ_COMPUTE;
  assign row_ok     = int'(in_data.row) < int'(dim);
  assign wr_ok      = (int'(in_data.row) < MAX_DIM) && (int'(in_data.col) < MAX_DIM);
  assign we_a       = accept && wr_ok && (in_data.req_type == mpmp_pkg::REQ_WR_A);
  assign we_b       = accept && wr_ok && (in_data.req_type == mpmp_pkg::REQ_WR_B);
  assign waddr      = AW'(int'(in_data.row) * MAX_DIM + int'(in_data.col));
  assign wdata      = WEIGHT_W'(in_data.weight);
  assign raddr_a    = AW'(int'(row_r) * MAX_DIM + int'(k_r));
  assign raddr_b    = AW'(int'(k_r) * MAX_DIM + int'(c_r));
  assign k_last     = int'(k_r) == int'(dim) - 1;
  assign c_last     = int'(c_r) == int'(dim) - 1;
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpmp_pkg::ST_IDLE: begin
        if (in_valid && is_compute && row_ok) begin
          state_nxt = mpmp_pkg::ST_RUN;
        end
      end
      mpmp_pkg::ST_RUN: begin
        if (k_last) begin
          state_nxt = mpmp_pkg::ST_WAIT;
        end
      end
      mpmp_pkg::ST_WAIT: begin
        if (done) begin
          state_nxt = mpmp_pkg::ST_EMIT;
        end
      end
      mpmp_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = c_last ? mpmp_pkg::ST_IDLE : mpmp_pkg::ST_RUN;
        end
      end
      default: state_nxt = mpmp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = state_r == mpmp_pkg::ST_IDLE;
    issue.vld   = state_r == mpmp_pkg::ST_RUN;
    issue.first = k_r == '0;
    issue.last  = k_last;
    emit        = (state_r == mpmp_pkg::ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mpmp_pkg::ST_IDLE;
      issue_d_r <= '0;
    end else begin
      state_r   <= state_nxt;
      issue_d_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_compute) begin
      row_r <= CW'(in_data.row);
      k_r   <= '0;
      c_r   <= '0;
    end else begin
      if (issue.vld) begin
        k_r <= k_last ? '0 : k_r + CW'(1);
      end
      if (emit) begin
        c_r <= c_r + CW'(1);
      end
    end
  end

  mpmp_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WEIGHT_W)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mpmp_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WEIGHT_W)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  mpmp_acc #(
    .WEIGHT_W (WEIGHT_W)
  ) u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (issue_d_r),
    .a     (rdata_a),
    .b     (rdata_b),
    .best  (best),
    .done  (done)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.out_row   <= mpmp_pkg::IDX_W'(row_r);
      out_data_r.out_col   <= mpmp_pkg::IDX_W'(c_r);
      out_data_r.out_value <= mpmp_pkg::VALUE_W'(best);
      out_data_r.last      <= c_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/mpmp_ram.sv */
// single-port-write, single-port-read synchronous memory with registered read data
module mpmp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/mpmp_acc.sv */
// saturating add and running minimum over one product column
module mpmp_acc #(
  parameter int WEIGHT_W = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mpmp_pkg::acc_ctl_t    ctl,
  input  logic [WEIGHT_W-1:0]   a,
  input  logic [WEIGHT_W-1:0]   b,
  output logic [WEIGHT_W-1:0]   best,
  output logic                  done
);

  localparam logic [WEIGHT_W-1:0] INF = '1;

  logic [WEIGHT_W:0]    sum;
  logic [WEIGHT_W-1:0]  term;
  logic [WEIGHT_W-1:0]  term_r;
  logic [WEIGHT_W-1:0]  best_r;
  mpmp_pkg::acc_ctl_t   tctl_r;
  logic                 done_r;

  // any infinite operand pushes the sum to or past the infinity code
  always_comb begin
    sum  = {1'b0, a} + {1'b0, b};
    term = (sum >= {1'b0, INF}) ? INF : sum[WEIGHT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tctl_r <= '0;
      done_r <= 1'b0;
    end else begin
      tctl_r <= ctl;
      done_r <= tctl_r.vld && tctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    term_r <= term;
    if (tctl_r.vld && (tctl_r.first || (term_r < best_r))) begin
      best_r <= term_r;
    end
  end

  assign best = best_r;
  assign done = done_r;

endmodule
